// ===== rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

   // Fixed field widths of the request and response channels.
   localparam int KEY_W      = 32;
   localparam int TOTAL_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * KEY_W - TOTAL_W;

   // Operation carried in the request tuser.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Completion codes carried in the response tuser.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Control from the channel logic to the heap engine.
   typedef struct packed {
      logic start;   // a request is taken this cycle
      logic ack;     // the finished result is taken this cycle
   } ctl_type;

   // Engine status seen by the channel logic.
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

   // One finished result.
   typedef struct packed {
      status_type               status;
      logic [TOTAL_W-1:0]       total;
      logic signed [KEY_W-1:0]  cur_min;
      logic signed [KEY_W-1:0]  popped;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/bmhq_sift.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhq_sift #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bmhq_pkg::ctl_type                     ctl,
   input  wire logic                                  cmd_func,
   input  wire logic signed [bmhq_pkg::KEY_W-1:0]     cmd_key,
   output      bmhq_pkg::eng_stat_type                stat,
   output      bmhq_pkg::result_type                  result
);

   import bmhq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_RD,
      S_DN_CMP,
      S_FIN
   } state_type;

   state_type               state_ff,   state_in;
   logic [CW-1:0]           cnt_ff,     cnt_in;
   logic [CW-1:0]           pos_ff,     pos_in;
   logic signed [KEY_W-1:0] hold_ff,    hold_in;
   logic signed [KEY_W-1:0] root_ff,    root_in;
   logic signed [KEY_W-1:0] popped_ff,  popped_in;
   status_type              status_ff,  status_in;
   logic                    right_ff,   right_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [KEY_W-1:0]        wr_data;
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;
   logic [KEY_W-1:0]        rd_data_a;
   logic [KEY_W-1:0]        rd_data_b;

   logic [AW-1:0]           pos_addr;
   logic [AW-1:0]           parent_addr;
   logic [AW-1:0]           last_addr;
   logic [CW:0]             left_pos;
   logic [CW:0]             cnt_ext;
   logic                    pick_right;
   logic signed [KEY_W-1:0] child_val;
   logic [CW-1:0]           child_pos;

   // The heap lives in one memory; position p is held at entry p-1.
   bmhq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Addresses around the hole that moves through the heap.
   assign pos_addr    = AW'(pos_ff - ONE_CNT);
   assign parent_addr = AW'((pos_ff >> 1) - ONE_CNT);
   assign last_addr   = AW'(cnt_ff - ONE_CNT);
   assign left_pos    = {pos_ff, 1'b0};
   assign cnt_ext     = {1'b0, cnt_ff};

   // Smaller child, the left one on a tie.
   assign pick_right = right_ff && ($signed(rd_data_b) < $signed(rd_data_a));
   assign child_val  = pick_right ? $signed(rd_data_b) : $signed(rd_data_a);
   assign child_pos  = CW'(left_pos + (CW + 1)'(pick_right));

   // Sequencer: one memory read step and one compare per level, the moving key
   // is kept in a register and written once it has found its place.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      hold_in   = hold_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      right_in  = right_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_addr;
      wr_data   = hold_ff;
      rd_addr_a = parent_addr;
      rd_addr_b = AW'(left_pos);

      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               popped_in = '0;
               status_in = ST_OK;
               if (cmd_func == FUNC_PUSH) begin
                  if (cnt_ff == CAP_CNT) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN;
                  end else begin
                     cnt_in   = cnt_ff + ONE_CNT;
                     pos_in   = cnt_ff + ONE_CNT;
                     hold_in  = cmd_key;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     popped_in = root_ff;
                     cnt_in    = cnt_ff - ONE_CNT;
                     pos_in    = ONE_CNT;
                     rd_addr_a = last_addr;
                     state_in  = (cnt_ff == ONE_CNT) ? S_FIN : S_DN_LAST;
                  end
               end
            end
         end

         // Sift up: fetch the parent unless the hole has reached the root.
         S_UP_RD: begin
            if (pos_ff == ONE_CNT) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr_a = parent_addr;
               state_in  = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (hold_ff < $signed(rd_data_a)) begin
               wr_data  = rd_data_a;
               pos_in   = pos_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         // Pop: the old last element becomes the moving key.
         S_DN_LAST: begin
            hold_in  = $signed(rd_data_a);
            state_in = S_DN_RD;
         end

         // Sift down: fetch both children at once.
         S_DN_RD: begin
            if (left_pos > cnt_ext) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr_a = AW'(left_pos - (CW + 1)'(1));
               rd_addr_b = AW'(left_pos);
               right_in  = left_pos < cnt_ext;
               state_in  = S_DN_CMP;
            end
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (child_val < hold_ff) begin
               wr_data  = child_val;
               pos_in   = child_pos;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The root is shadowed so that the minimum never costs a read.
   assign root_in = (wr_en && (wr_addr == '0)) ? $signed(wr_data) : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff    <= pos_in;
      hold_ff   <= hold_in;
      root_ff   <= root_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      right_ff  <= right_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_FIN);

   assign result.status  = status_ff;
   assign result.total   = TOTAL_W'(cnt_ff);
   assign result.cur_min = (cnt_ff != '0) ? root_ff : '0;
   assign result.popped  = popped_ff;

   // The count never exceeds the capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_CNT)
      else $error("heap count beyond capacity");

   // A rejected request agrees with the count it reports.
   a_flag_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |->
         ((status_ff != ST_FULL || cnt_ff == CAP_CNT) &&
          (status_ff != ST_EMPTY || cnt_ff == '0)))
      else $error("status flag does not match the count");

   // The count only moves when a request is taken.
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(cnt_ff))
      else $error("count changed during a sift");

   // A new request never lands on a busy engine.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == S_IDLE))
      else $error("request started while busy");

   // A sift-up compare always has a parent to look at.
   a_up_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_CMP) |-> (pos_ff > ONE_CNT))
      else $error("sift-up compare at the root");

endmodule

`default_nettype wire

// ===== rtl/binary_min_heap_queue_core.sv =====
// Binary min-heap priority queue of signed 32-bit keys, CAPACITY entries deep, held in one
// on-chip memory with two registered read ports and one write port. Each request is a push
// (req_tuser 0, key in req_tdata) or a pop (req_tuser 1) and gives exactly one response with
// the popped key, the minimum left in the heap, the count and a status code (0 ok, 1 pop on
// empty heap, 2 push on full heap; a flagged request changes nothing). Requests are served one
// at a time. A push moves its key up, and a pop moves the old last key down, one level per
// read-then-compare step on the heap memory. A finished response sits in an output register,
// so the next request is taken while it waits. The memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_core #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [bmhq_pkg::REQ_DATA_W-1:0]     req_tdata,  // [31:0] key_in
   input  wire logic                                req_tuser,  // [0] func
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [31:0] popped_key, [63:32] current_min, [74:64] element_total, [79:75] zero
   output      logic [bmhq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic [bmhq_pkg::STATUS_W-1:0]       rsp_tuser   // [1:0] status
);

   import bmhq_pkg::*;

   ctl_type       ctl;
   eng_stat_type  stat;
   result_type    result;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff,       rsp_in;

   // Heap engine with its memory.
   bmhq_sift #(
      .CAPACITY (CAPACITY)
   ) u_sift (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cmd_func (req_tuser),
      .cmd_key  ($signed(req_tdata[KEY_W-1:0])),
      .stat     (stat),
      .result   (result)
   );

   // A request is taken whenever the engine is free, even with a response pending.
   assign req_tready = stat.idle;
   assign ctl.start  = req_tvalid && req_tready;
   assign ctl.ack    = stat.done && (!rsp_valid_ff || rsp_tready);

   // Output register: loaded from the engine once the previous response has gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.total, rsp_ff.cur_min, rsp_ff.popped};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire
